// ----- hw/rtl/fbdr_pkg.sv -----
// Package for the flat-bottom distance restraint unit.
// Holds the field widths, configuration register codes and pipeline types.
// No dependencies.
package fbdr_pkg;

  // Atom count; a power of two, so an index wraps by dropping upper bits
  localparam int unsigned MaxAtoms  = 1024;

  // Field and datapath widths
  localparam int unsigned CoordW    = 24;
  localparam int unsigned DeltaW    = 25;
  localparam int unsigned SqW       = 50;
  localparam int unsigned RootW     = 25;
  localparam int unsigned RemSqW    = 27;
  localparam int unsigned SqrtSteps = 25;
  localparam int unsigned ExcW      = 25;
  localparam int unsigned ExcSqW    = 50;
  localparam int unsigned SpringW   = 24;
  localparam int unsigned PmagW     = 49;
  localparam int unsigned NumW      = 74;
  localparam int unsigned QuotW     = 37;
  localparam int unsigned DivW      = 37;
  localparam int unsigned DivSteps  = 37;
  localparam int unsigned EnergyW   = 48;
  localparam int unsigned GradW     = 40;
  localparam int unsigned IdxW      = $clog2(MaxAtoms);
  localparam int unsigned CfgW      = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned FracW     = 12;
  localparam int unsigned InDataW   = 144;
  localparam int unsigned OutDataW  = 192;

  // Configuration register codes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_LEN     = 3'd0,
    CFG_MAX_LEN     = 3'd1,
    CFG_SPRING      = 3'd2,
    CFG_FIRST_ATOM  = 3'd3,
    CFG_SECOND_ATOM = 3'd4
  } cfg_idx_e;

  // Per-axis delta magnitude and sign, carried down the front of the pipe
  typedef struct packed {
    logic [2:0][DeltaW-1:0] dmag;
    logic [2:0]             dneg;
  } vec_t;

  // Side information carried alongside the divider lanes
  typedef struct packed {
    logic [EnergyW-1:0] energy;
    logic               viol;
    logic               e_neg;
    logic [2:0]         dneg;
    logic [2:0]         zero;
    logic [DivW-1:0]    divisor;
  } div_ctl_t;

endpackage

// ----- hw/rtl/flat_bottom_distance_restraint_unit.sv -----
// Flat-bottom harmonic distance restraint, pipelined from input beat to result beat.
// Throughput one beat per cycle while the output is not stalled; the depth is set by the 25-step square root pipe
// and the 37-step restoring divider that forms the gradient quotient.
// The whole pipe advances together whenever the output register is empty or taken.
// Reset (rst_ni low, asynchronous) clears all valid bits and the configuration registers.
// Depends on fbdr_pkg.
module flat_bottom_distance_restraint_unit
  import fbdr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InDataW-1:0]   s_axis_tdata_i,   // ax, ay, az, bx, by, bz (24 b each)
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutDataW-1:0]  m_axis_tdata_o,   // energy 48, grad_x 40, grad_y 40,
                                                 // grad_z 40, first_index 10,
                                                 // second_index 10, zero pad 4
  output logic                 m_axis_tuser_o    // violated
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0]    min_len_q, max_len_q, spring_q;
  logic [IdxW-1:0]    first_atom_q, second_atom_q;
  logic [IdxW-1:0]    atom_wrap;

  // atom count is a power of two: the wrap keeps the low index bits
  assign atom_wrap = cfg_data_i[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q     <= '0;
      max_len_q     <= '0;
      spring_q      <= '0;
      first_atom_q  <= '0;
      second_atom_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_LEN:     min_len_q     <= cfg_data_i;
        CFG_MAX_LEN:     max_len_q     <= cfg_data_i;
        CFG_SPRING:      spring_q      <= cfg_data_i;
        CFG_FIRST_ATOM:  first_atom_q  <= atom_wrap;
        CFG_SECOND_ATOM: second_atom_q <= atom_wrap;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance: the pipe moves when the output register can take a beat
  // ---------------------------------------------------------------------------
  logic m_valid_q;
  logic adv;

  assign adv             = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // ---------------------------------------------------------------------------
  // Stage A: per-axis difference, magnitude and sign
  // ---------------------------------------------------------------------------
  logic a_v_q;
  vec_t a_vec_q, a_vec_d;

  always_comb begin
    logic signed [DeltaW-1:0] dlt;
    a_vec_d = '0;
    for (int i = 0; i < 3; i++) begin
      dlt = DeltaW'($signed(s_axis_tdata_i[i*CoordW +: CoordW]))
          - DeltaW'($signed(s_axis_tdata_i[(i+3)*CoordW +: CoordW]));
      a_vec_d.dneg[i] = dlt[DeltaW-1];
      a_vec_d.dmag[i] = dlt[DeltaW-1] ? DeltaW'(-dlt) : DeltaW'(dlt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else if (adv) a_v_q <= s_axis_tvalid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) a_vec_q <= a_vec_d;
  end

  // ---------------------------------------------------------------------------
  // Stage B: squares of the three magnitudes
  // ---------------------------------------------------------------------------
  logic                 b_v_q;
  vec_t                 b_vec_q;
  logic [2:0][SqW-1:0]  b_sqr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_v_q <= 1'b0;
    else if (adv) b_v_q <= a_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_vec_q <= a_vec_q;
      for (int i = 0; i < 3; i++) begin
        b_sqr_q[i] <= SqW'(a_vec_q.dmag[i]) * SqW'(a_vec_q.dmag[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C and square root pipe: one root bit per stage
  // ---------------------------------------------------------------------------
  logic              sr_v_q    [SqrtSteps+1];
  vec_t              sr_vec_q  [SqrtSteps+1];
  logic [SqW-1:0]    sr_src_q  [SqrtSteps+1];
  logic [RemSqW-1:0] sr_rem_q  [SqrtSteps+1];
  logic [RootW-1:0]  sr_root_q [SqrtSteps+1];

  // stage C: sum of squares seeds the root pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sr_v_q[0] <= 1'b0;
    else if (adv) sr_v_q[0] <= b_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sr_vec_q[0]  <= b_vec_q;
      sr_src_q[0]  <= b_sqr_q[0] + b_sqr_q[1] + b_sqr_q[2];
      sr_rem_q[0]  <= '0;
      sr_root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam int unsigned Hi = SqW - 1 - 2*k;
    logic [RemSqW+1:0] rem_in;
    logic [RemSqW+1:0] trial;
    logic [RemSqW-1:0] rem_d;
    logic [RootW-1:0]  root_d;

    // bring down two bits, try subtracting 4*root+1
    always_comb begin
      rem_in = {sr_rem_q[k], sr_src_q[k][Hi -: 2]};
      trial  = (RemSqW+2)'({sr_root_q[k], 2'b01});
      if (rem_in >= trial) begin
        rem_d  = RemSqW'(rem_in - trial);
        root_d = {sr_root_q[k][RootW-2:0], 1'b1};
      end else begin
        rem_d  = RemSqW'(rem_in);
        root_d = {sr_root_q[k][RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sr_v_q[k+1] <= 1'b0;
      else if (adv) sr_v_q[k+1] <= sr_v_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sr_vec_q[k+1]  <= sr_vec_q[k];
        sr_src_q[k+1]  <= sr_src_q[k];
        sr_rem_q[k+1]  <= rem_d;
        sr_root_q[k+1] <= root_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: bound test and excess
  // ---------------------------------------------------------------------------
  logic              d_v_q;
  vec_t              d_vec_q;
  logic [RootW-1:0]  d_dist_q, dist_s;
  logic [ExcW-1:0]   d_exc_q, exc_d;
  logic              d_viol_q, d_eneg_q, viol_d, eneg_d;

  assign dist_s = sr_root_q[SqrtSteps];

  always_comb begin
    viol_d = 1'b0;
    eneg_d = 1'b0;
    exc_d  = '0;
    if (dist_s < RootW'(min_len_q)) begin
      viol_d = 1'b1;
      eneg_d = 1'b1;
      exc_d  = ExcW'(RootW'(min_len_q) - dist_s);
    end else if (dist_s > RootW'(max_len_q)) begin
      viol_d = 1'b1;
      exc_d  = ExcW'(dist_s - RootW'(max_len_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_v_q <= 1'b0;
    else if (adv) d_v_q <= sr_v_q[SqrtSteps];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_vec_q  <= sr_vec_q[SqrtSteps];
      d_dist_q <= dist_s;
      d_exc_q  <= exc_d;
      d_viol_q <= viol_d;
      d_eneg_q <= eneg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: excess squared and k times excess
  // ---------------------------------------------------------------------------
  logic              e_v_q;
  vec_t              e_vec_q;
  logic [RootW-1:0]  e_dist_q;
  logic              e_viol_q, e_eneg_q;
  logic [ExcSqW-1:0] e_exc2_q;
  logic [PmagW-1:0]  e_pmag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_v_q <= 1'b0;
    else if (adv) e_v_q <= d_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_vec_q  <= d_vec_q;
      e_dist_q <= d_dist_q;
      e_viol_q <= d_viol_q;
      e_eneg_q <= d_eneg_q;
      e_exc2_q <= ExcSqW'(d_exc_q) * ExcSqW'(d_exc_q);
      e_pmag_q <= PmagW'(spring_q) * PmagW'(d_exc_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: partial products for energy and gradient numerators
  // ---------------------------------------------------------------------------
  localparam int unsigned SplitW = 25;

  logic                   f_v_q;
  vec_t                   f_vec_q;
  logic [RootW-1:0]       f_dist_q;
  logic                   f_viol_q, f_eneg_q;
  logic [PmagW-1:0]       f_en_hi_q, f_en_lo_q;
  logic [2:0][PmagW-1:0]  f_np_hi_q;
  logic [2:0][SqW-1:0]    f_np_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_v_q <= 1'b0;
    else if (adv) f_v_q <= e_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_vec_q   <= e_vec_q;
      f_dist_q  <= e_dist_q;
      f_viol_q  <= e_viol_q;
      f_eneg_q  <= e_eneg_q;
      f_en_hi_q <= PmagW'(spring_q) * PmagW'(e_exc2_q[ExcSqW-1:SplitW]);
      f_en_lo_q <= PmagW'(spring_q) * PmagW'(e_exc2_q[SplitW-1:0]);
      for (int i = 0; i < 3; i++) begin
        f_np_hi_q[i] <= PmagW'(e_pmag_q[PmagW-1:SplitW]) * PmagW'(e_vec_q.dmag[i]);
        f_np_lo_q[i] <= SqW'(e_pmag_q[SplitW-1:0]) * SqW'(e_vec_q.dmag[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage G: energy with saturation, numerators, divisor; seeds the divider
  // ---------------------------------------------------------------------------
  logic                  dv_v_q   [DivSteps+1];
  div_ctl_t              dv_ctl_q [DivSteps+1];
  logic [2:0][DivW-1:0]  dv_rem_q [DivSteps+1];
  logic [2:0][QuotW-1:0] dv_quo_q [DivSteps+1];
  logic [2:0][QuotW-1:0] dv_low_q [DivSteps+1];

  logic [PmagW:0]        en_sum;
  div_ctl_t              g_ctl_d;
  logic [2:0][NumW-1:0]  num_d;

  always_comb begin
    en_sum = (PmagW+1)'(f_en_hi_q) + (PmagW+1)'(f_en_lo_q >> SplitW);
    g_ctl_d.energy  = (en_sum[PmagW:EnergyW] != '0) ? '1 : EnergyW'(en_sum);
    if (!f_viol_q) g_ctl_d.energy = '0;
    g_ctl_d.viol    = f_viol_q;
    g_ctl_d.e_neg   = f_eneg_q;
    g_ctl_d.dneg    = f_vec_q.dneg;
    g_ctl_d.divisor = {f_dist_q, {FracW{1'b0}}};
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (NumW'(f_np_hi_q[i]) << SplitW) + NumW'(f_np_lo_q[i]);
      g_ctl_d.zero[i] = !f_viol_q || (f_dist_q == '0) || (f_vec_q.dmag[i] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else if (adv) dv_v_q[0] <= f_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_ctl_q[0] <= g_ctl_d;
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= num_d[i][NumW-1:QuotW];
        dv_low_q[0][i] <= num_d[i][QuotW-1:0];
        dv_quo_q[0][i] <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, three lanes, one quotient bit per stage
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int unsigned Bit = DivSteps - 1 - j;
    logic [2:0][DivW-1:0]  rem_d;
    logic [2:0][QuotW-1:0] quo_d;

    always_comb begin
      logic [DivW:0] part;
      logic [DivW:0] dsr;
      dsr = (DivW+1)'(dv_ctl_q[j].divisor);
      for (int i = 0; i < 3; i++) begin
        part = {dv_rem_q[j][i], dv_low_q[j][i][Bit]};
        if (part >= dsr) begin
          rem_d[i] = DivW'(part - dsr);
          quo_d[i] = {dv_quo_q[j][i][QuotW-2:0], 1'b1};
        end else begin
          rem_d[i] = DivW'(part);
          quo_d[i] = {dv_quo_q[j][i][QuotW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[j+1] <= 1'b0;
      else if (adv) dv_v_q[j+1] <= dv_v_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_ctl_q[j+1] <= dv_ctl_q[j];
        dv_low_q[j+1] <= dv_low_q[j];
        dv_rem_q[j+1] <= rem_d;
        dv_quo_q[j+1] <= quo_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: signs, zero cases, packing
  // ---------------------------------------------------------------------------
  logic [OutDataW-1:0]  m_data_q, m_data_d;
  logic                 m_user_q;
  div_ctl_t             o_ctl;
  logic [2:0][GradW-1:0] grad;

  assign o_ctl = dv_ctl_q[DivSteps];

  always_comb begin
    logic [GradW-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag = GradW'(dv_quo_q[DivSteps][i]);
      if (o_ctl.zero[i]) grad[i] = '0;
      else if (o_ctl.e_neg ^ o_ctl.dneg[i]) grad[i] = GradW'(-mag);
      else grad[i] = mag;
    end
    m_data_d = {4'b0, second_atom_q, first_atom_q, grad[2], grad[1], grad[0], o_ctl.energy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else if (adv) m_valid_q <= dv_v_q[DivSteps];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= m_data_d;
      m_user_q <= o_ctl.viol;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // inside the bounds a result carries no energy and no gradient
  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_user_q) |-> (m_data_q[EnergyW+3*GradW-1:0] == '0))
    else $error("non-zero energy or gradient inside bounds");

  // input side only stalls when the output register is held
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_valid_q || m_axis_tready_i))
    else $error("ready does not follow output occupancy");

  // floor square root: remainder never exceeds twice the root
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sr_v_q[SqrtSteps] |->
      ((RemSqW+1)'(sr_rem_q[SqrtSteps]) <= {1'b0, sr_root_q[SqrtSteps], 1'b0}))
    else $error("square root remainder out of range");

  // divider remainders end below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[DivSteps] && o_ctl.divisor != '0) |->
      (dv_rem_q[DivSteps][0] < o_ctl.divisor && dv_rem_q[DivSteps][1] < o_ctl.divisor
       && dv_rem_q[DivSteps][2] < o_ctl.divisor))
    else $error("divider remainder not below divisor");

  // a held result beat keeps its payload while the pipe is frozen
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |=> ($stable(m_data_q) && $stable(dv_v_q[0])))
    else $error("pipe moved during a stall");

endmodule

// ----- bench/flat_bottom_distance_restraint_unit_tb.sv -----
// Testbench for the flat-bottom distance restraint unit.
// Directed table then random coordinate pairs, each result checked against a local predictor or a typed-in result.
// Depends on fbdr_pkg and flat_bottom_distance_restraint_unit.
`timescale 1ns / 100ps

module flat_bottom_distance_restraint_unit_tb;
  import fbdr_pkg::*;

  localparam int unsigned NumRandom = 1620;
  localparam int unsigned Latency   = 70;
  localparam int unsigned WdogLimit = 4000;

  typedef struct packed {
    logic [47:0] energy;
    logic [39:0] gx;
    logic [39:0] gy;
    logic [39:0] gz;
    logic        viol;
    logic [9:0]  fidx;
    logic [9:0]  sidx;
  } restraint_t;

  // One directed row: coordinates, plus optional typed-in result
  typedef struct {
    logic [23:0] c [6];
    bit          has_exp;
    restraint_t  exp;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  flat_bottom_distance_restraint_unit DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor copy of the registers
  logic [23:0] lo_bound, hi_bound, spring_k;
  logic [9:0]  atom_a, atom_b;

  restraint_t  expected_q [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned out_wait = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Gradient on one axis: |k*e|*|delta|/dist truncated to Q.12, signed, saturated
  function automatic logic [39:0] axis_grad(input bit e_neg, input logic [63:0] pmag,
                                            input longint dlt, input logic [63:0] root_len);
    logic [63:0] dmag, q, r, x;
    longint g;
    if (root_len == 0 || dlt == 0) return '0;
    dmag = dlt < 0 ? -dlt : dlt;
    q = pmag / root_len;
    r = pmag % root_len;
    x = q * dmag + (r * dmag) / root_len;
    x >>= 12;
    if (x > 64'd549755813887) x = 64'd549755813887;
    g = (e_neg != (dlt < 0)) ? -longint'(x) : longint'(x);
    return g[39:0];
  endfunction

  function automatic restraint_t predict_restraint(input logic [23:0] c [6]);
    restraint_t  res;
    longint      dlt [3];
    logic [63:0] sq, root_len, emag, d2, en, pmag, m;
    bit          viol, e_neg;
    sq = 0; emag = 0; en = 0; viol = 0; e_neg = 0;
    for (int i = 0; i < 3; i++) begin
      dlt[i] = longint'($signed(c[i])) - longint'($signed(c[i+3]));
      m  = dlt[i] < 0 ? -dlt[i] : dlt[i];
      sq += m * m;
    end
    root_len = int_sqrt(sq);
    if (root_len < lo_bound) begin
      viol = 1; e_neg = 1; emag = lo_bound - root_len;
    end else if (root_len > hi_bound) begin
      viol = 1; emag = root_len - hi_bound;
    end
    if (viol) begin
      d2 = emag * emag;
      en = spring_k * (d2 >> 25) + ((spring_k * d2[24:0]) >> 25);
      if (en > 64'hFFFF_FFFF_FFFF) en = 64'hFFFF_FFFF_FFFF;
    end
    pmag       = spring_k * emag;
    res.energy = en[47:0];
    res.gx     = viol ? axis_grad(e_neg, pmag, dlt[0], root_len) : '0;
    res.gy     = viol ? axis_grad(e_neg, pmag, dlt[1], root_len) : '0;
    res.gz     = viol ? axis_grad(e_neg, pmag, dlt[2], root_len) : '0;
    res.viol   = viol;
    res.fidx   = atom_a;
    res.sidx   = atom_b;
    return res;
  endfunction

  // One register write; the enable is high for a single cycle, then drops before the next write
  task automatic write_reg(input cfg_idx_e idx, input logic [23:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_MIN_LEN:     lo_bound = val;
      CFG_MAX_LEN:     hi_bound = val;
      CFG_SPRING:      spring_k = val;
      CFG_FIRST_ATOM:  atom_a = val[9:0];
      CFG_SECOND_ATOM: atom_b = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_restraint(input logic [23:0] lo, input logic [23:0] hi,
                               input logic [23:0] k, input logic [23:0] a,
                               input logic [23:0] b);
    write_reg(CFG_MIN_LEN, lo);
    write_reg(CFG_MAX_LEN, hi);
    write_reg(CFG_SPRING, k);
    write_reg(CFG_FIRST_ATOM, a);
    write_reg(CFG_SECOND_ATOM, b);
  endtask

  // Wait for the pipe to drain before touching the registers
  task automatic drain_pipe();
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Send one beat after a random gap; expectation queued on acceptance.
  // Valid stays high after the beat; the next call with a non-zero gap, or drain_pipe, drops it.
  task automatic send_pair(input logic [23:0] c [6], input bit has_exp,
                           input restraint_t exp);
    int unsigned gap;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {c[5], c[4], c[3], c[2], c[1], c[0]};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(has_exp ? exp : predict_restraint(c));
  endtask

  function automatic logic [23:0] rand_coord(input int unsigned spread);
    case ($urandom_range(5))
      0:       return 24'($urandom());
      1:       return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(2 * spread)) - $signed(spread));
    endcase
  endfunction

  // Result side: a drawn wait per beat, compare with oldest expectation
  always @(posedge clk_i) begin
    restraint_t got, exp;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.energy = m_axis_tdata_o[47:0];
        got.gx     = m_axis_tdata_o[87:48];
        got.gy     = m_axis_tdata_o[127:88];
        got.gz     = m_axis_tdata_o[167:128];
        got.fidx   = m_axis_tdata_o[177:168];
        got.sidx   = m_axis_tdata_o[187:178];
        got.viol   = m_axis_tuser_o;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata_o);
        end else begin
          exp = expected_q.pop_front();
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp e=%h g=%h/%h/%h v=%b i=%0d/%0d got e=%h g=%h/%h/%h v=%b i=%0d/%0d",
                       exp.energy, exp.gx, exp.gy, exp.gz, exp.viol, exp.fidx, exp.sidx,
                       got.energy, got.gx, got.gy, got.gz, got.viol, got.fidx, got.sidx);
          end
        end
        out_wait = ($urandom_range(3) == 0) ? $urandom_range(16) : 0;
      end else if (out_wait != 0) begin
        out_wait--;
      end
      m_axis_tready_i <= (out_wait == 0);
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WdogLimit) begin
      $display("flat_bottom_distance_restraint_unit_tb failed");
      $finish;
    end
  end

  initial begin
    stim_row_t   rows [$];
    stim_row_t   r;
    logic [23:0] c [6];
    restraint_t  none;
    int unsigned spread;
    none        = '0;
    lo_bound = 0; hi_bound = 0; spring_k = 0; atom_a = 0; atom_b = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset: k zero, so any distance gives zero energy and gradient
    r.has_exp = 1;
    r.exp = '0; r.exp.viol = 1;
    r.c = '{24'h001000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0};
    rows.push_back(r);
    r.exp.viol = 0;
    r.c = '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0};
    rows.push_back(r);
    foreach (rows[i]) send_pair(rows[i].c, rows[i].has_exp, rows[i].exp);
    rows.delete();
    drain_pipe();

    // Extremes of the coordinates, zero distance, axis-aligned pairs and one mixed pair
    set_restraint(24'h002000, 24'h004000, 24'h001000, 24'd5, 24'd1023);
    r.has_exp = 0;
    r.c = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000};
    rows.push_back(r);
    r.c = '{24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF};
    rows.push_back(r);
    r.c = '{24'h123456, 24'h654321, 24'h0ABCDE, 24'h123456, 24'h654321, 24'h0ABCDE};
    rows.push_back(r);
    r.c = '{24'h003000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0};
    rows.push_back(r);
    r.c = '{24'h0, 24'hFFD000, 24'h0, 24'h0, 24'h0, 24'h0};
    rows.push_back(r);
    r.c = '{24'h0, 24'h0, 24'h000800, 24'h0, 24'h0, 24'h0};
    rows.push_back(r);
    r.c = '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h010000};
    rows.push_back(r);
    r.c = '{24'hFFFFFF, 24'h000001, 24'hAAAAAA, 24'h555555, 24'h0, 24'hFFFFFF};
    rows.push_back(r);
    foreach (rows[i]) send_pair(rows[i].c, rows[i].has_exp, rows[i].exp);
    rows.delete();
    drain_pipe();

    // Full-scale bounds and spring; then crossed bounds
    set_restraint(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1023, 24'd0);
    r.c = '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0};
    rows.push_back(r);
    r.c = '{24'h000001, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0};
    rows.push_back(r);
    r.c = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000};
    rows.push_back(r);
    foreach (rows[i]) send_pair(rows[i].c, rows[i].has_exp, rows[i].exp);
    rows.delete();
    drain_pipe();
    set_restraint(24'h008000, 24'h002000, 24'h00FFFF, 24'd7, 24'd9);
    r.c = '{24'h001000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0};
    rows.push_back(r);
    r.c = '{24'h009000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0};
    rows.push_back(r);
    r.c = '{24'h005000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0};
    rows.push_back(r);
    foreach (rows[i]) send_pair(rows[i].c, rows[i].has_exp, rows[i].exp);
    rows.delete();
    drain_pipe();

    // Random phases, new restraint settings between them
    for (int ph = 0; ph < 6; ph++) begin
      set_restraint(24'($urandom_range(1) ? $urandom_range(24'h00A000) : $urandom()),
                    24'($urandom()),
                    24'($urandom_range(1) ? $urandom_range(24'h010000) : $urandom()),
                    24'($urandom()), 24'($urandom()));
      if (hi_bound < lo_bound && $urandom_range(3) != 0) write_reg(CFG_MAX_LEN, lo_bound + 24'h4000);
      spread = 32'(lo_bound > hi_bound ? lo_bound : hi_bound) + 32'h2000;
      if (spread > 24'h7FFFFF || spread == 0) spread = 24'h7FFFFF;
      for (int n = 0; n < NumRandom / 6; n++) begin
        foreach (c[i]) c[i] = rand_coord(spread / 2);
        send_pair(c, 0, none);
        if (n == 100) begin
          s_axis_tvalid_i <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk_i);
        end
      end
      drain_pipe();
    end

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("flat_bottom_distance_restraint_unit_tb passed");
    end else begin
      $display("flat_bottom_distance_restraint_unit_tb failed");
    end
    $finish;
  end

endmodule
